>>> design/ppm_pkg.sv
// Shared types and constants for the point proximity match table.
`default_nettype none

package ppm_pkg;

    localparam int COORD_W = 24;
    localparam int NCOORD  = 4;
    localparam int SQ_W    = 49;
    localparam int SUM_W   = 52;
    localparam int DIM_W   = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 1'd1;

    localparam logic [DIM_W-1:0] DIM_RESET       = 3'd2;
    localparam logic [SUM_W-1:0] THRESHOLD_RESET = 52'd65536;

    typedef enum logic [1:0] {
        KIND_ADD   = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        kind_t  kind;
        coord_t coord_0;
        coord_t coord_1;
        coord_t coord_2;
        coord_t coord_3;
    } item_t;

    typedef struct packed {
        logic       found;
        logic       table_full;
        logic [8:0] stored_points;
    } result_t;

    // One table entry moving down the row of distance cells
    typedef struct packed {
        logic                vld;
        logic                last;
        logic [SUM_W-1:0]    sum;
        coord_t [NCOORD-1:0] pt;
    } flow_t;

endpackage

`default_nettype wire

>>> design/ppm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ppm_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/ppm_cell.sv
// Distance cell: adds its squared coordinate difference, if IDX < dim, to the sum.
`default_nettype none

module ppm_cell
    import ppm_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire coord_t           q_coord,
    input  wire logic [DIM_W-1:0] dim,
    input  wire flow_t            flow_in,
    output flow_t                 flow_out
);

    localparam logic [DIM_W:0] IDX_CMP = (DIM_W+1)'(IDX);

    coord_t            q_reg;
    flow_t             a_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SQ_W-1:0]   sq_next;
    flow_t             out_reg;
    flow_t             out_next;
    logic signed [COORD_W:0]     diff;
    logic signed [2*COORD_W+1:0] prod;
    logic              en;

    assign en   = {1'b0, dim} > IDX_CMP;
    assign diff = $signed({q_reg[COORD_W-1], q_reg})
                - $signed({flow_in.pt[IDX][COORD_W-1], flow_in.pt[IDX]});
    assign prod = diff * diff;

    always_comb
    begin
        sq_next = en ? prod[SQ_W-1:0] : '0;
        out_next = a_reg;
        out_next.sum = a_reg.sum + SUM_W'(sq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= q_coord;
        end
        sq_reg <= sq_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg   <= '0;
            out_reg <= '0;
        end
        else
        begin
            a_reg   <= flow_in;
            out_reg <= out_next;
        end
    end

    assign flow_out = out_reg;

endmodule

`default_nettype wire

>>> design/point_proximity_match_table_core.sv
// Add, clear and ignored kinds give their result in the cycle after the transfer;
// so does a query on an empty table.
// A query reads the N stored points: the table RAM delivers one entry per cycle
// into a row of distance cells, two register stages each.
// Throughput: one add, clear or ignored item per cycle; busy is high while a query runs.
// Reset empties the table, sets dimensions to 2 and match_threshold to 65536.
`default_nettype none

module point_proximity_match_table_core
    import ppm_pkg::*;
#(
    parameter int MAX_POINTS = 256,
    parameter int MAX_DIM    = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire item_t                item,
    output logic                      done,
    output result_t                   result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SUM_W-1:0]     cfg_data
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int NCELL  = (MAX_DIM < NCOORD) ? MAX_DIM : NCOORD;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              rd_last_reg, rd_last_next;
    logic              found_reg, found_next;
    logic              done_reg, done_next;
    result_t           res_reg, res_next;
    logic [DIM_W-1:0]  dim_reg;
    logic [SUM_W-1:0]  thr_reg;

    logic                    accept;
    logic                    we;
    logic                    load;
    logic                    hit;
    logic [CNT_W+8:0]        cnt_ext;
    coord_t [NCOORD-1:0]     in_pt;
    logic [NCOORD*COORD_W-1:0] rdata;
    flow_t                   flow [NCELL+1];

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = res_reg;

    assign in_pt[0] = item.coord_0;
    assign in_pt[1] = item.coord_1;
    assign in_pt[2] = item.coord_2;
    assign in_pt[3] = item.coord_3;

    ppm_ram #(
        .WIDTH (NCOORD * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (in_pt),
        .re    (state_reg == ST_SCAN),
        .raddr (rd_addr_reg),
        .rdata (rdata)
    );

    assign flow[0] = {rd_vld_reg, rd_last_reg, {SUM_W{1'b0}}, rdata};

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        ppm_cell #(
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load),
            .q_coord  (in_pt[g]),
            .dim      (dim_reg),
            .flow_in  (flow[g]),
            .flow_out (flow[g+1])
        );
    end

    assign hit = flow[NCELL].sum < thr_reg;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rd_addr_next = rd_addr_reg;
        rd_vld_next  = 1'b0;
        rd_last_next = 1'b0;
        found_next   = found_reg;
        done_next    = 1'b0;
        res_next     = res_reg;
        we           = 1'b0;
        load         = 1'b0;

        if (flow[NCELL].vld && hit)
        begin
            found_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next.found      = 1'b0;
                    res_next.table_full = 1'b0;
                    unique case (item.kind)
                        KIND_ADD:
                        begin
                            done_next = 1'b1;
                            if (count_reg < CNT_MAX)
                            begin
                                we         = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                res_next.table_full = 1'b1;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                load         = 1'b1;
                                found_next   = 1'b0;
                                rd_addr_next = '0;
                                state_next   = ST_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            done_next  = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_vld_next  = 1'b1;
                rd_last_next = (CNT_W'(rd_addr_reg) == count_reg - CNT_W'(1));
                rd_addr_next = rd_addr_reg + ADDR_W'(1);
                if (rd_last_next)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (flow[NCELL].vld && flow[NCELL].last)
                begin
                    done_next           = 1'b1;
                    res_next.found      = found_next;
                    res_next.table_full = 1'b0;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        cnt_ext = {9'd0, count_next};
        if (done_next)
        begin
            res_next.stored_points = cnt_ext[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_last_reg <= 1'b0;
            done_reg    <= 1'b0;
            found_reg   <= 1'b0;
            dim_reg     <= DIM_RESET;
            thr_reg     <= THRESHOLD_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_vld_reg  <= rd_vld_next;
            rd_last_reg <= rd_last_next;
            done_reg    <= done_next;
            found_reg   <= found_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DIMENSIONS:      dim_reg <= cfg_data[DIM_W-1:0];
                    REG_MATCH_THRESHOLD: thr_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

>>> design/ppm_checker.sv
// Port-level checks for the point proximity match table, bound to the top level.
`default_nettype none

module ppm_checker
    import ppm_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 busy,
    input  wire item_t                item,
    input  wire logic                 done,
    input  wire result_t              result,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SUM_W-1:0]     cfg_data
);

    // Non-query items finish in the next cycle
    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind != KIND_QUERY) |=> done)
        else $error("add/clear/ignored item did not finish in one cycle");

    // Every transfer either starts a scan or finishes at once
    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor done");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.found && result.table_full))
        else $error("found and table_full both set");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> (result.stored_points != 9'd0))
        else $error("table reported full with no stored points");

endmodule

bind point_proximity_match_table_core ppm_checker u_ppm_checker (.*);

`default_nettype wire
